// ===== design/lruc_pkg.sv =====
package lruc_pkg;

    localparam int SLOT_W = 4;
    localparam int OP_W   = 2;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [SLOT_W-1:0] slot_t;

    localparam op_t OP_LOOKUP = 2'd0;
    localparam op_t OP_INSERT = 2'd1;
    localparam op_t OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic capture;
        logic execute;
    } lruc_cmd_t;

endpackage

// ===== design/lruc_ctrl.sv =====
module lruc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output lruc_pkg::lruc_cmd_t cmd
);

    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   execute;

    assign in_ready    = (state_reg == ST_IDLE);
    assign execute     = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign cmd.capture = in_ready && in_valid;
    assign cmd.execute = execute;
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (execute)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/lruc_datapath.sv =====
module lruc_datapath
#(
    parameter int ENTRIES    = 8,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lruc_pkg::lruc_cmd_t   cmd,
    input  lruc_pkg::op_t         operation,
    input  logic [KEY_BITS-1:0]   lookup_key,
    input  logic [VALUE_BITS-1:0] store_value,
    output logic                  hit,
    output logic [VALUE_BITS-1:0] found_value
);

    localparam int PW = $clog2(ENTRIES);

    lruc_pkg::op_t         op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  hit_reg;
    logic [VALUE_BITS-1:0] found_reg;

    lruc_pkg::slot_t       list_reg  [ENTRIES];
    lruc_pkg::slot_t       list_next [ENTRIES];
    logic [KEY_BITS-1:0]   keys_reg  [ENTRIES];
    logic [VALUE_BITS-1:0] values_reg[ENTRIES];

    logic [ENTRIES-1:0]    slot_match;
    logic [ENTRIES-1:0]    pos_hit;
    logic                  any_hit;
    logic [PW-1:0]         hit_pos;
    lruc_pkg::slot_t       hit_slot;
    lruc_pkg::slot_t       hit_slot_m1;
    lruc_pkg::slot_t       used;
    lruc_pkg::slot_t       ins_slot;
    lruc_pkg::slot_t       ins_slot_m1;
    lruc_pkg::slot_t       cur_m1;

    // parallel key compare and recency search
    always_comb
    begin
        for (int s = 0; s < ENTRIES; s++)
        begin
            slot_match[s] = (keys_reg[s] == key_reg);
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            cur_m1     = list_reg[i] - lruc_pkg::slot_t'(1);
            pos_hit[i] = (list_reg[i] != '0) && slot_match[cur_m1[PW-1:0]];
        end
        any_hit = 1'b0;
        hit_pos = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (pos_hit[i])
            begin
                any_hit = 1'b1;
                hit_pos = PW'(i);
            end
        end
        used = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (list_reg[i] != '0)
            begin
                used = used + lruc_pkg::slot_t'(1);
            end
        end
    end

    assign hit_slot    = list_reg[hit_pos];
    assign hit_slot_m1 = hit_slot - lruc_pkg::slot_t'(1);
    assign ins_slot    = (list_reg[ENTRIES-1] != '0) ? list_reg[ENTRIES-1]
                                                     : used + lruc_pkg::slot_t'(1);
    assign ins_slot_m1 = ins_slot - lruc_pkg::slot_t'(1);

    // next recency order
    always_comb
    begin
        for (int j = 0; j < ENTRIES; j++)
        begin
            list_next[j] = list_reg[j];
        end
        unique case (op_reg)
            lruc_pkg::OP_LOOKUP:
            begin
                if (any_hit)
                begin
                    list_next[0] = hit_slot;
                    for (int j = 1; j < ENTRIES; j++)
                    begin
                        if (PW'(j) <= hit_pos)
                        begin
                            list_next[j] = list_reg[j-1];
                        end
                    end
                end
            end
            lruc_pkg::OP_INSERT:
            begin
                list_next[0] = ins_slot;
                for (int j = 1; j < ENTRIES; j++)
                begin
                    list_next[j] = list_reg[j-1];
                end
            end
            lruc_pkg::OP_CLEAR:
            begin
                for (int j = 0; j < ENTRIES; j++)
                begin
                    list_next[j] = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < ENTRIES; j++)
            begin
                list_reg[j] <= '0;
            end
        end
        else if (cmd.execute)
        begin
            for (int j = 0; j < ENTRIES; j++)
            begin
                list_reg[j] <= list_next[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= operation;
            key_reg   <= lookup_key;
            value_reg <= store_value;
        end
        if (cmd.execute)
        begin
            if (op_reg == lruc_pkg::OP_INSERT)
            begin
                keys_reg[ins_slot_m1[PW-1:0]]   <= key_reg;
                values_reg[ins_slot_m1[PW-1:0]] <= value_reg;
            end
            hit_reg   <= (op_reg == lruc_pkg::OP_LOOKUP) && any_hit;
            found_reg <= ((op_reg == lruc_pkg::OP_LOOKUP) && any_hit)
                         ? values_reg[hit_slot_m1[PW-1:0]] : '0;
        end
    end

    assign hit         = hit_reg;
    assign found_value = found_reg;

endmodule

// ===== design/lru_cache_8way_unit.sv =====
// Fully associative key/value cache with true least-recently-used order.
// Each transaction on the slave side carries an operation in tuser (lookup,
// insert or clear) and a key and value in tdata; every transaction yields
// exactly one result transaction on the master side, with hit in tuser and
// the found value (zero unless a lookup hit) in tdata. Each transaction
// first registers the input; then all stored keys are compared in parallel
// and the recency list, key and value slots and result register are
// updated. A new input is taken while an earlier result still waits;
// execution holds only when the result register is still full.
// Insert does not check for duplicate keys: a lookup returns the most
// recently used match. Clear empties the recency list at once.
module lru_cache_8way_unit
#(
    parameter int ENTRIES    = 8,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // lookup_key, store_value
    input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // operation
    input  logic [lruc_pkg::OP_W-1:0]                    s_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // found_value
    output logic [((VALUE_BITS+7)/8)*8-1:0]              m_axis_tdata,
    // hit
    output logic                                         m_axis_tuser
);

    localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8;

    lruc_pkg::lruc_cmd_t   cmd;
    logic [VALUE_BITS-1:0] found_value;

    lruc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    lruc_datapath
    #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (s_axis_tuser),
        .lookup_key  (s_axis_tdata[KEY_BITS-1:0]),
        .store_value (s_axis_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS]),
        .hit         (m_axis_tuser),
        .found_value (found_value)
    );

    assign m_axis_tdata = OUT_W'(found_value);

endmodule

// ===== sim/lru_cache_8way_unit_test.sv =====
`timescale 1ns / 1ps

module lru_cache_8way_unit_test;

    localparam int ENTRIES      = 8;
    localparam int KEY_BITS     = 32;
    localparam int VALUE_BITS   = 32;
    localparam lruc_pkg::op_t OP_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 650;
    localparam int POOL_SIZE    = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic                  hit;
        logic [VALUE_BITS-1:0] value;
    } cache_result_t;

    class cache_scoreboard;
        lruc_pkg::slot_t       order [ENTRIES];
        logic [KEY_BITS-1:0]   keys [ENTRIES];
        logic [VALUE_BITS-1:0] values [ENTRIES];
        cache_result_t         due_results [$];
        int                    errors;

        function new();
            errors = 0;
            foreach (order[i])
            begin
                order[i] = '0;
                keys[i] = '0;
                values[i] = '0;
            end
        endfunction

        function void take_request(lruc_pkg::op_t op, logic [KEY_BITS-1:0] key,
                                   logic [VALUE_BITS-1:0] value);
            cache_result_t   r;
            lruc_pkg::slot_t s;
            int              i;
            int              used;
            r.hit = 1'b0;
            r.value = '0;
            unique case (op)
                lruc_pkg::OP_LOOKUP:
                begin
                    for (i = 0; i < ENTRIES; i++)
                    begin
                        if (order[i] == 0)
                            break;
                        if (keys[order[i]-1] == key)
                        begin
                            r.hit = 1'b1;
                            r.value = values[order[i]-1];
                            s = order[i];
                            for (int j = i; j > 0; j--)
                                order[j] = order[j-1];
                            order[0] = s;
                            break;
                        end
                    end
                end
                lruc_pkg::OP_INSERT:
                begin
                    s = order[ENTRIES-1];
                    // still filling: take the next unused slot
                    if (s == 0)
                    begin
                        used = 0;
                        while (used < ENTRIES && order[used] != 0)
                            used++;
                        s = lruc_pkg::slot_t'(used + 1);
                    end
                    keys[s-1] = key;
                    values[s-1] = value;
                    for (i = ENTRIES - 1; i > 0; i--)
                        order[i] = order[i-1];
                    order[0] = s;
                end
                lruc_pkg::OP_CLEAR:
                begin
                    foreach (order[k])
                        order[k] = '0;
                end
                default:
                begin
                end
            endcase
            due_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task match_response(logic hit, logic [VALUE_BITS-1:0] value);
            cache_result_t want;
            if (due_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result hit=%b value=%h", hit, value));
                return;
            end
            want = due_results.pop_front();
            if (hit !== want.hit)
                report_mismatch($sformatf("hit %b, predicted %b", hit, want.hit));
            if (value !== want.value)
                report_mismatch($sformatf("found_value %h, predicted %h", value, want.value));
        endtask
    endclass

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [KEY_BITS+VALUE_BITS-1:0] s_data = '0;
    logic [lruc_pkg::OP_W-1:0]      s_user = lruc_pkg::OP_LOOKUP;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [VALUE_BITS-1:0]          m_data;
    logic                           m_user;

    cache_scoreboard sb = new();

    bit                  tx_idle_on = 1'b1;
    bit                  rx_idle_on = 1'b1;
    int                  hold_request = 0;
    int                  hold_left = 0;
    int                  cycles = 0;
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

    lru_cache_8way_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task send_op(lruc_pkg::op_t op, logic [KEY_BITS-1:0] key,
                 logic [VALUE_BITS-1:0] value);
        while (tx_idle_on && $urandom_range(0, 99) < 33)
        begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user <= op;
        s_data <= {value, key};
        @(posedge clk);
        while (s_ready !== 1'b1)
            @(posedge clk);
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // receiver: random back-pressure plus one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_ready <= 1'b0;
                hold_left--;
            end
            else
                m_ready <= !(rx_idle_on && $urandom_range(0, 99) < 33);
        end
    end

    always @(posedge clk)
    begin
        if (m_valid === 1'b1 && m_ready)
            sb.match_response(m_user, m_data);
        if (s_valid && s_ready === 1'b1)
            sb.take_request(s_user, s_data[KEY_BITS-1:0], s_data[KEY_BITS +: VALUE_BITS]);
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[lru_cache_8way_unit] ERROR");
        $finish;
    end

    initial
    begin
        int            n;
        int            pick;
        lruc_pkg::op_t op;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty lookup, extremes, duplicates, unused code, eviction, clear
        send_op(lruc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_op(lruc_pkg::OP_INSERT, 32'h0000_0000, 32'hffff_ffff);
        send_op(lruc_pkg::OP_INSERT, 32'hffff_ffff, 32'h0000_0000);
        send_op(lruc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_op(lruc_pkg::OP_LOOKUP, 32'hffff_ffff, 32'hffff_ffff);
        send_op(lruc_pkg::OP_LOOKUP, 32'h1234_5678, 32'h0000_0000);
        send_op(lruc_pkg::OP_INSERT, 32'h0000_0000, 32'ha5a5_a5a5);
        send_op(lruc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_op(OP_NONE, 32'h0000_0000, $urandom());
        send_op(lruc_pkg::OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
        send_op(lruc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        for (n = 0; n < ENTRIES + 2; n++)
            send_op(lruc_pkg::OP_INSERT, 32'h100 + n, 32'h5a5a_0000 + n);
        send_op(lruc_pkg::OP_LOOKUP, 32'h100, 32'h0000_0000);
        send_op(lruc_pkg::OP_LOOKUP, 32'h102, 32'h0000_0000);
        send_op(lruc_pkg::OP_LOOKUP, 32'h109, 32'h0000_0000);
        send_op(lruc_pkg::OP_INSERT, 32'h5555_5555, 32'haaaa_aaaa);
        send_op(lruc_pkg::OP_LOOKUP, 32'h5555_5555, 32'h0000_0000);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                foreach (key_pool[k])
                    key_pool[k] = $urandom();
            tx_idle_on = !(n >= 200 && n < 320);
            rx_idle_on = tx_idle_on;
            if (n == 400)
                hold_request = HOLD_CYCLES;
            pick = $urandom_range(0, 99);
            if (pick < 50)
                op = lruc_pkg::OP_LOOKUP;
            else if (pick < 93)
                op = lruc_pkg::OP_INSERT;
            else if (pick < 96)
                op = lruc_pkg::OP_CLEAR;
            else
                op = OP_NONE;
            send_op(op, pick_key(), $urandom());
        end
        s_valid <= 1'b0;

        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("[lru_cache_8way_unit] OK");
        else
            $display("[lru_cache_8way_unit] ERROR");
        $finish;
    end

endmodule
